FILE: rtl/moving_average_with_jump_reset_unit_assert.svh
// Assertion macros shared by the moving average checker.
`ifndef MOVING_AVERAGE_WITH_JUMP_RESET_UNIT_ASSERT_SVH
`define MOVING_AVERAGE_WITH_JUMP_RESET_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MAWJR_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mawjr assertion failed");

// Next-cycle implication, disabled during reset.
`define MAWJR_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mawjr assertion failed");

`endif

FILE: rtl/mawjr_pkg.sv
// Package: constants, widths, register codes and command type of the moving average unit.
`timescale 1ns / 1ps
`default_nettype none
package mawjr_pkg;
  localparam int MAX_WINDOW = 8;
  localparam int SAMPLE_W   = 32;
  localparam int WL_W       = 4;
  localparam int JL_W       = 31;
  localparam int FILL_W     = 4;
  localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int DIV_STEPS  = (SUM_W + 3) / 4;
  localparam int DIV_W      = 4 * DIV_STEPS;
  localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_JUMP_LIMIT    = 1'b1;

  localparam logic [WL_W-1:0] WL_RESET = 4'd8;
  localparam logic [JL_W-1:0] JL_RESET = 31'd655;

  typedef struct packed {
    logic capture;
    logic check;
    logic read_old;
    logic update;
    logic div_load;
    logic div_step;
    logic load_result;
  } mawjr_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/mawjr_if.sv
// Stream interfaces for sample items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface mawjr_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mawjr_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] average;
  logic [3:0]         fill_count;
  modport source (output valid, output average, output fill_count, input ready);
  modport sink (input valid, input average, input fill_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/mawjr_ctrl.sv
// Controller: sequences one item through check, update, divide and result load.
`timescale 1ns / 1ps
`default_nettype none
module mawjr_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  wire                   div_done,
  output mawjr_pkg::mawjr_cmd_t cmd
);
  import mawjr_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_READ    = 3'd2;
  localparam logic [2:0] ST_WRITE   = 3'd3;
  localparam logic [2:0] ST_DIVLOAD = 3'd4;
  localparam logic [2:0] ST_DIV     = 3'd5;
  localparam logic [2:0] ST_FIX     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       result_free;

  assign in_ready    = (state == ST_IDLE);
  assign result_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read_old = 1'b1;
        state_next   = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.update = 1'b1;
        state_next = ST_DIVLOAD;
      end
      ST_DIVLOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_done) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        // hold until the output register is free
        if (result_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_result) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/mawjr_datapath.sv
// Datapath: sample ring, running sum, jump test and radix-16 divider by the fill count.
`timescale 1ns / 1ps
`default_nettype none
module mawjr_datapath (
  input  wire                                  clk,
  input  wire                                  rst,
  input  mawjr_pkg::mawjr_cmd_t                cmd,
  input  wire signed [mawjr_pkg::SAMPLE_W-1:0] sample,
  input  wire [mawjr_pkg::WL_W-1:0]            window_length,
  input  wire [mawjr_pkg::JL_W-1:0]            jump_limit,
  output logic                                 div_done,
  output logic signed [mawjr_pkg::SAMPLE_W-1:0] average,
  output logic [mawjr_pkg::FILL_W-1:0]         fill_count
);
  import mawjr_pkg::*;

  // window state
  logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];
  logic [PTR_W-1:0]           ptr;
  logic [CNT_W-1:0]           cnt;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] newest;

  // per-item working registers
  logic signed [SAMPLE_W-1:0] s_reg;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   ndiff;
  logic signed [SAMPLE_W-1:0] old;
  logic [DIV_W-1:0]           div_q;
  logic [CNT_W-1:0]           rem;
  logic [CNT_W-1:0]           divisor;
  logic                       neg;
  logic [STEP_W-1:0]          step;

  logic [CNT_W-1:0]           len;
  logic signed [DIFF_W-1:0]   lim;
  logic                       jump;
  logic                       drop;
  logic [CNT_W:0]             wr_sum;
  logic [PTR_W-1:0]           wr_addr;
  logic [PTR_W-1:0]           ptr_inc;
  logic [SUM_W-1:0]           mag;
  logic [CNT_W-1:0]           step_rem;
  logic [3:0]                 step_digit;
  logic [CNT_W:0]             trial;
  logic [SAMPLE_W-1:0]        quot;

  always_comb begin
    if (window_length == '0) begin
      len = CNT_W'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = CNT_W'(window_length);
    end
  end

  assign lim  = $signed({2'b00, jump_limit});
  assign jump = (cnt != '0) && ((diff > lim) || (ndiff > lim));

  // drop the oldest once the window has reached its length
  assign drop    = (cnt >= len);
  assign wr_sum  = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(cnt);
  assign wr_addr = (wr_sum >= (CNT_W + 1)'(MAX_WINDOW)) ?
                   PTR_W'(wr_sum - (CNT_W + 1)'(MAX_WINDOW)) : PTR_W'(wr_sum);
  assign ptr_inc = (ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr + PTR_W'(1);
  assign mag     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  // four restoring steps on the top digit of the dividend
  always_comb begin
    step_rem   = rem;
    step_digit = '0;
    trial      = '0;
    for (int i = 0; i < 4; i++) begin
      trial = {step_rem, div_q[DIV_W-1-i]};
      if (trial >= {1'b0, divisor}) begin
        step_digit[3-i] = 1'b1;
        trial           = trial - {1'b0, divisor};
      end
      step_rem = trial[CNT_W-1:0];
    end
  end

  assign div_done = (step == STEP_W'(DIV_STEPS - 1));
  assign quot     = div_q[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      cnt    <= '0;
      sum    <= '0;
      newest <= '0;
    end else if (cmd.check) begin
      if (jump) begin
        ptr <= '0;
        cnt <= '0;
        sum <= '0;
      end
    end else if (cmd.read_old) begin
      sum <= sum + SUM_W'(s_reg);
    end else if (cmd.update) begin
      newest <= s_reg;
      if (drop) begin
        sum <= sum - SUM_W'(old);
        ptr <= ptr_inc;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_old) begin
      old <= ring[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ring[wr_addr] <= s_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_reg <= sample;
      diff  <= DIFF_W'(sample) - DIFF_W'(newest);
      ndiff <= DIFF_W'(newest) - DIFF_W'(sample);
    end
    if (cmd.div_load) begin
      neg     <= sum[SUM_W-1];
      div_q   <= DIV_W'(mag);
      rem     <= '0;
      divisor <= cnt;
      step    <= '0;
    end else if (cmd.div_step) begin
      div_q <= {div_q[DIV_W-5:0], step_digit};
      rem   <= step_rem;
      step  <= step + STEP_W'(1);
    end
    if (cmd.load_result) begin
      average    <= neg ? $signed(-quot) : $signed(quot);
      fill_count <= FILL_W'(cnt);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/moving_average_with_jump_reset_unit.sv
// The unit takes one sample item at a time and takes no new item until its result is loaded.
// Each item runs through the jump check, the window update and a radix-16 divide by the fill count.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous, active high) empties the window, clears sum and last sample,
// and sets window_length to 8 and jump_limit to 655. The sample ring itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module moving_average_with_jump_reset_unit (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire [mawjr_pkg::PADDR_W-1:0]        paddr,
  input  wire [mawjr_pkg::PDATA_W-1:0]        pwdata,
  output logic [mawjr_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready,
  mawjr_sample_if.sink                        samples,
  mawjr_result_if.source                      results
);
  import mawjr_pkg::*;

  logic [WL_W-1:0] window_length;
  logic [JL_W-1:0] jump_limit;
  logic            reg_sel;
  logic            wr_en;
  logic            div_done;
  mawjr_cmd_t      cmd;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_RESET;
      jump_limit    <= JL_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_WINDOW_LENGTH: window_length <= pwdata[WL_W-1:0];
        REG_JUMP_LIMIT:    jump_limit    <= pwdata[JL_W-1:0];
        default:           window_length <= window_length;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WINDOW_LENGTH: prdata = PDATA_W'(window_length);
      REG_JUMP_LIMIT:    prdata = PDATA_W'(jump_limit);
      default:           prdata = '0;
    endcase
  end

  mawjr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  mawjr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sample        (samples.sample),
    .window_length (window_length),
    .jump_limit    (jump_limit),
    .div_done      (div_done),
    .average       (results.average),
    .fill_count    (results.fill_count)
  );
endmodule
`default_nettype wire

FILE: rtl/mawjr_checker.sv
// Port-level checker for the moving average unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "moving_average_with_jump_reset_unit_assert.svh"
module mawjr_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] average,
  input wire [3:0]  fill_count
);
  import mawjr_pkg::*;

  // a stalled result item holds
  `MAWJR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(average) && $stable(fill_count))

  // one item at a time: no accept right after an accept
  `MAWJR_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // a result never reports an empty or overfull window
  `MAWJR_ASSERT_IMPLY(a_fill_range, clk, rst, out_valid, (fill_count != 4'd0) && (32'(fill_count) <= MAX_WINDOW))
endmodule

bind moving_average_with_jump_reset_unit mawjr_checker u_mawjr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .average    (results.average),
  .fill_count (results.fill_count)
);
`default_nettype wire
